// ===== design/oaat_pkg.sv =====
// Shared types, constants and mix functions for the one-at-a-time bucket hash.
package oaat_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned MIX_ADD_SHIFT  = 10;
    localparam int unsigned MIX_XOR_SHIFT  = 6;
    localparam int unsigned FIN_ADD1_SHIFT = 3;
    localparam int unsigned FIN_XOR_SHIFT  = 11;
    localparam int unsigned FIN_ADD2_SHIFT = 15;
    localparam t_word       BUCKET_COUNT_RESET = 32'd1024;

    typedef struct packed {
        logic  push;
        t_word hash;
    } t_qwr;

    typedef struct packed {
        logic  empty;
        t_word hash;
    } t_qrd;

    function automatic t_word absorb_byte(t_word h, logic [7:0] b);
        t_word x;
        x = h + {24'd0, b};
        x = x + (x << MIX_ADD_SHIFT);
        x = x ^ (x >> MIX_XOR_SHIFT);
        return x;
    endfunction

    function automatic t_word final_mix(t_word h);
        t_word x;
        x = h + (h << FIN_ADD1_SHIFT);
        x = x ^ (x >> FIN_XOR_SHIFT);
        x = x + (x << FIN_ADD2_SHIFT);
        return x;
    endfunction

endpackage

// ===== design/oaat_ifs.sv =====
// Valid/ready channel interfaces for key bytes, results and the bucket count write.
interface oaat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       byte_present;
    logic       last_byte;

    modport source (output valid, output key_byte, output byte_present, output last_byte,
                    input ready);
    modport sink   (input valid, input key_byte, input byte_present, input last_byte,
                    output ready);
endinterface

interface oaat_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] full_hash;
    logic [31:0] bucket_index;

    modport source (output valid, output full_hash, output bucket_index, input ready);
    modport sink   (input valid, input full_hash, input bucket_index, output ready);
endinterface

interface oaat_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] bucket_count;

    modport source (output valid, output bucket_count, input ready);
    modport sink   (input valid, input bucket_count, output ready);
endinterface

// ===== design/oaat_front.sv =====
// Front end: absorb key bytes into the running hash and queue finished keys.
module oaat_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    oaat_in_if.sink             i_in,
    input  logic                i_q_full,
    output oaat_pkg::t_qwr      o_qwr
);
    import oaat_pkg::*;

    t_word r_hash;
    t_word n_hash;
    t_word w_mixed;
    logic  w_accept;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_mixed = i_in.byte_present ? absorb_byte(r_hash, i_in.key_byte) : r_hash;
        n_hash  = r_hash;
        if (w_accept) begin
            n_hash = i_in.last_byte ? '0 : w_mixed;
        end
    end

    assign o_qwr.push = w_accept && i_in.last_byte;
    assign o_qwr.hash = w_mixed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

// ===== design/oaat_fifo.sv =====
// Short queue of absorbed key hashes between the front and back ends.
module oaat_fifo #(
    parameter int unsigned P_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oaat_pkg::t_qwr      i_qwr,
    input  logic                i_pop,
    output logic                o_full,
    output oaat_pkg::t_qrd      o_qrd
);
    import oaat_pkg::*;

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_word           r_mem [P_DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full      = (r_count == CW'(P_DEPTH));
    assign o_qrd.empty = (r_count == '0);
    assign o_qrd.hash  = r_mem[r_rptr];
    assign w_push      = i_qwr.push && !o_full;
    assign w_pop       = i_pop && !o_qrd.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_qwr.hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(P_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(P_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/oaat_back.sv =====
// Back end: final mix, bit-serial remainder by the bucket count, result register.
module oaat_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oaat_pkg::t_qrd      i_qrd,
    input  oaat_pkg::t_word     i_bucket_count,
    output logic                o_pop,
    oaat_out_if.source          o_out
);
    import oaat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [4:0]  r_cnt;
    t_word       r_full;
    t_word       r_dvd;
    t_word       r_div;
    logic [32:0] r_rem;
    logic [32:0] w_shift;
    logic        w_ge;

    assign w_shift = {r_rem[31:0], r_dvd[31]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    assign o_pop              = (r_state == S_IDLE) && !i_qrd.empty;
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.full_hash    = r_full;
    assign o_out.bucket_index = r_rem[31:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qrd.empty) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_full <= final_mix(i_qrd.hash);
            r_dvd  <= final_mix(i_qrd.hash);
            r_div  <= i_bucket_count;
            r_rem  <= '0;
        end else if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
        end
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_div != '0) |-> (r_rem < {1'b0, r_div}))
        else $error("remainder not below bucket count");

    a_zero_div_passes_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_div == '0) |-> (o_out.bucket_index == r_full))
        else $error("zero bucket count must give the full hash");

    a_pop_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_DIV && r_cnt == '0))
        else $error("pop did not start a division");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != 5'd31) |=> (r_state == S_DIV))
        else $error("division left early");

endmodule

// ===== design/one_at_a_time_bucket_hash.sv =====
// Top level: one-at-a-time key hash with bucket reduction.
// Key bytes are taken one per cycle while the hash queue has room.
// A key's hash is queued, popped by an idle back end, final-mixed, then reduced by the
// 32-step serial remainder unit; no new key is popped until the last result is taken.
// Reset clears the running hash, the queue and the back end state; bucket count is 1024.
module one_at_a_time_bucket_hash #(
    parameter int unsigned P_QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oaat_in_if.sink     i_in,
    oaat_cfg_if.sink    i_cfg,
    oaat_out_if.source  o_out
);
    import oaat_pkg::*;

    t_word r_bucket_count;
    t_qwr  w_qwr;
    t_qrd  w_qrd;
    logic  w_q_full;
    logic  w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_bucket_count <= i_cfg.bucket_count;
        end
    end

    oaat_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_qwr    (w_qwr)
    );

    oaat_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (w_qwr),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_qrd   (w_qrd)
    );

    oaat_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qrd          (w_qrd),
        .i_bucket_count (r_bucket_count),
        .o_pop          (w_pop),
        .o_out          (o_out)
    );

endmodule

// ===== sim/oaat_hash_checker.sv =====
// Watches the key, bucket-count and result channels, predicts each key's hash and compares.
`timescale 1ns / 1ps

module oaat_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oaat_in_if          i_key,
    oaat_cfg_if         i_cfg,
    oaat_out_if         i_hash,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    import oaat_pkg::*;

    typedef struct {
        t_word full;
        t_word bucket;
    } t_hash_result;

    t_hash_result expected_hashes[$];
    t_hash_result oldest;
    t_word        running_hash;
    t_word        bucket_count;
    t_word        finished;
    t_word        bucket;
    int unsigned  fail_tally;

    function automatic t_word mix_in_byte(t_word h, logic [7:0] b);
        t_word acc;
        acc = h + t_word'(b);
        acc = acc + (acc << 10);
        acc = acc ^ (acc >> 6);
        return acc;
    endfunction

    function automatic t_word finish_hash(t_word h);
        t_word acc;
        acc = h + (h << 3);
        acc = acc ^ (acc >> 11);
        acc = acc + (acc << 15);
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("%0t hash check: %s got %h want %h", $realtime, what, got, want);
        fail_tally++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_hashes.delete();
            running_hash = '0;
            bucket_count = BUCKET_COUNT_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                bucket_count = i_cfg.bucket_count;
            end
            if (i_key.valid && i_key.ready) begin
                if (i_key.byte_present) begin
                    running_hash = mix_in_byte(running_hash, i_key.key_byte);
                end
                if (i_key.last_byte) begin
                    finished = finish_hash(running_hash);
                    bucket = (bucket_count != '0) ? (finished % bucket_count) : finished;
                    expected_hashes.push_back('{full: finished, bucket: bucket});
                    running_hash = '0;
                end
            end
            if (i_hash.valid && i_hash.ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("result with none pending", i_hash.full_hash, '0);
                end else begin
                    oldest = expected_hashes.pop_front();
                    if (i_hash.full_hash !== oldest.full) begin
                        report_mismatch("full_hash", i_hash.full_hash, oldest.full);
                    end
                    if (i_hash.bucket_index !== oldest.bucket) begin
                        report_mismatch("bucket_index", i_hash.bucket_index, oldest.bucket);
                    end
                end
            end
        end
        o_pending    <= expected_hashes.size();
        o_fail_count <= fail_tally;
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the bench: clock, reset, key and bucket-count stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;
    import oaat_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned WORDS_PER_PHASE = 185;
    localparam int unsigned PHASE_COUNT     = 8;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_go;
    bit          hold_off_done;

    oaat_in_if  key_if ();
    oaat_cfg_if cfg_if ();
    oaat_out_if hash_if ();

    one_at_a_time_bucket_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .i_cfg   (cfg_if),
        .o_out   (hash_if)
    );

    oaat_hash_checker hash_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (key_if),
        .i_cfg        (cfg_if),
        .i_hash       (hash_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        hash_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go && !hold_off_done) begin
                hold_off_done = 1'b1;
                hash_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                hash_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_key_word(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            key_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        key_if.valid        <= 1'b1;
        key_if.key_byte     <= b;
        key_if.byte_present <= present;
        key_if.last_byte    <= last;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(input t_word count);
        cfg_if.valid        <= 1'b1;
        cfg_if.bucket_count <= count;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        key_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Return the number of counted (non-noise) words sent.
    task automatic send_random_key(output int unsigned words);
        int unsigned len;
        int unsigned n;
        logic [7:0]  b;
        bit          closed;
        words  = 0;
        closed = 1'b0;
        len    = ($urandom_range(99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        for (n = 0; n < len; n++) begin
            if ($urandom_range(99) < 6) begin
                send_key_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            case ($urandom_range(15))
                0:       b = 8'h00;
                1:       b = 8'h7f;
                2:       b = 8'h80;
                3:       b = 8'hff;
                default: b = 8'($urandom_range(255));
            endcase
            closed = (n == len - 1) && ($urandom_range(99) >= 10);
            send_key_word(b, 1'b1, closed);
            words++;
        end
        if (!closed) begin
            send_key_word(8'($urandom_range(255)), 1'b0, 1'b1);
            words++;
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_words;
        int unsigned key_words;
        t_word       count;

        i_rst_n             <= 1'b0;
        key_if.valid        <= 1'b0;
        key_if.key_byte     <= '0;
        key_if.byte_present <= 1'b0;
        key_if.last_byte    <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.bucket_count <= '0;
        send_idle_pct = 32;
        recv_idle_pct = 57;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_key_word(8'h3c, 1'b0, 1'b1);
        send_key_word(8'h00, 1'b1, 1'b1);
        send_key_word(8'hff, 1'b1, 1'b1);
        send_key_word(8'h80, 1'b1, 1'b1);
        send_key_word(8'h7f, 1'b1, 1'b1);
        send_key_word(8'h61, 1'b1, 1'b0);
        send_key_word(8'h55, 1'b0, 1'b0);
        send_key_word(8'h00, 1'b1, 1'b0);
        send_key_word(8'h62, 1'b1, 1'b0);
        send_key_word(8'haa, 1'b0, 1'b1);
        send_key_word(8'h55, 1'b1, 1'b0);
        send_key_word(8'haa, 1'b1, 1'b1);
        send_key_word(8'h01, 1'b1, 1'b0);
        send_key_word(8'h02, 1'b1, 1'b1);
        send_key_word(8'h00, 1'b0, 1'b0);
        send_key_word(8'hff, 1'b0, 1'b1);
        wait_for_drain();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                1:       count = 32'd0;
                2:       count = 32'd1;
                3:       count = 32'hffff_ffff;
                4:       count = t_word'($urandom_range(2, 100));
                5:       count = 32'h8000_0000;
                6:       count = t_word'($urandom);
                7:       count = 32'd3;
                default: count = BUCKET_COUNT_RESET;
            endcase
            if (phase != 0) begin
                write_bucket_count(count);
            end
            if (phase < 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 57;
            end else if (phase < 6) begin
                send_idle_pct = 57;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 1) begin
                hold_off_go = 1'b1;
            end
            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE) begin
                send_random_key(key_words);
                phase_words += key_words;
            end
            wait_for_drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/oaat_pkg.sv
design/oaat_ifs.sv
design/oaat_front.sv
design/oaat_fifo.sv
design/oaat_back.sv
design/one_at_a_time_bucket_hash.sv
sim/oaat_hash_checker.sv
sim/testbench.sv
